FILE: rtl/stack_machine_execute_macros.svh
// Assertion macros for the stack machine block.
`ifndef STACK_MACHINE_EXECUTE_MACROS_SVH
`define STACK_MACHINE_EXECUTE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SME_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define SME_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define SME_ASSERT_IMP(label, clk, rst_n, a, b)
`define SME_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: rtl/sme_pkg.sv
// ---------------------------------------------------------------------------
// sme_pkg: shared types and codes
// Command and status codes and the stack geometry of the stack machine.
// ---------------------------------------------------------------------------
package sme_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int PW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] CMD_PUSH  = 4'd0;
    localparam logic [3:0] CMD_POP   = 4'd1;
    localparam logic [3:0] CMD_SWAP  = 4'd2;
    localparam logic [3:0] CMD_ADD   = 4'd3;
    localparam logic [3:0] CMD_SUB   = 4'd4;
    localparam logic [3:0] CMD_MUL   = 4'd5;
    localparam logic [3:0] CMD_DIV   = 4'd6;
    localparam logic [3:0] CMD_MOD   = 4'd7;
    localparam logic [3:0] CMD_PINT  = 4'd8;
    localparam logic [3:0] CMD_PCHAR = 4'd9;
    localparam logic [3:0] CMD_PALL  = 4'd10;
    localparam logic [3:0] CMD_NOP   = 4'd11;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_DIVZERO = 3'd2;
    localparam logic [2:0] ST_RANGE   = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_UNKNOWN = 3'd5;

    localparam logic [31:0] CHAR_MAX = 32'd127;

    // Request to the divider and its answer.
    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [31:0] rem;
    } t_div_rsp;
endpackage

FILE: rtl/sme_divider.sv
// ---------------------------------------------------------------------------
// sme_divider: signed restoring divider
// One quotient bit per cycle; truncates toward zero, remainder follows the
// dividend's sign.
// ---------------------------------------------------------------------------
module sme_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sme_pkg::t_div_req i_req,
    output sme_pkg::t_div_rsp o_rsp
);
    import sme_pkg::*;

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [31:0] r_q;
    logic [31:0] r_rem;
    logic [31:0] r_d;
    logic        r_nq;
    logic        r_nr;
    logic        r_done;
    logic [32:0] w_trial;
    logic [32:0] w_sub;

    // One shift and trial subtract per cycle.
    assign w_trial = {r_rem, r_q[31]};
    assign w_sub   = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_q    <= i_req.a[31] ? (32'd0 - i_req.a) : i_req.a;
                r_d    <= i_req.b[31] ? (32'd0 - i_req.b) : i_req.b;
                r_rem  <= '0;
                r_nq   <= i_req.a[31] ^ i_req.b[31];
                r_nr   <= i_req.a[31];
            end else if (r_busy) begin
                // The partial remainder stays below the divisor, so 32 bits hold it.
                if (!w_sub[32]) begin
                    r_rem <= w_sub[31:0];
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= w_trial[31:0];
                    r_q   <= {r_q[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_nq ? (32'd0 - r_q) : r_q;
    assign o_rsp.rem  = r_nr ? (32'd0 - r_rem) : r_rem;
endmodule

FILE: rtl/stack_machine_execute.sv
// This block runs one stack command per input beat and answers with result
// beats. Each command reads the top entry and the one below it (S_RDB, S_RDA)
// and is decoded in S_EXE, where push writes and pop, nop, pint, pchar and
// errors go straight to S_OUT; add, sub and mul write one entry and swap two
// in S_WR2, through the one write port of the stack memory; div and mod wait
// in S_DIV for the one-bit-per-cycle divider; pall walks the memory top down.
// The input is not ready while a command runs; a held result register lets the
// next beat be taken while a result waits; a stalled result side holds S_OUT or S_PALL.
// ---------------------------------------------------------------------------
// stack_machine_execute: stack machine top level
// Sequencer, stack memory and shared arithmetic unit.
// ---------------------------------------------------------------------------
module stack_machine_execute (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] operand
    input  logic [3:0]  s_axis_tuser,  // [3:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [2:0] status, [34:3] value, rest zero
    output logic [1:0]  m_axis_tuser,  // [0] has_value, [1] is_char
    output logic        m_axis_tlast
);
    import sme_pkg::*;
    `include "stack_machine_execute_macros.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDB  = 3'd1;
    localparam logic [2:0] S_RDA  = 3'd2;
    localparam logic [2:0] S_EXE  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_WR2  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;
    localparam logic [2:0] S_PALL = 3'd7;

    logic [2:0]  r_state;
    logic [3:0]  r_cmd;
    logic [31:0] r_opnd;
    logic [CW-1:0] r_count;
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [CW-1:0] r_idx;
    logic        r_wait;

    logic [31:0] r_mem [STACK_DEPTH];
    logic [31:0] r_rdata;
    logic        r_we;
    logic [PW-1:0] r_waddr;
    logic [31:0] r_wdata;
    logic [PW-1:0] w_raddr;

    logic [2:0]  r_res_status;
    logic        r_res_has;
    logic [31:0] r_res_val;
    logic        r_res_char;

    logic        r_ovalid;
    logic [2:0]  r_ostatus;
    logic        r_ohas;
    logic [31:0] r_oval;
    logic        r_ochar;
    logic        r_olast;

    t_div_req    w_dreq;
    t_div_rsp    w_drsp;
    logic [31:0] w_prod;
    logic [31:0] w_alu;
    logic        w_oslot;

    // Stack memory: one write, one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mem[r_waddr] <= r_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    sme_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    assign w_prod = r_a * r_b;
    always_comb begin
        case (r_cmd)
            CMD_ADD: w_alu = r_a + r_b;
            CMD_SUB: w_alu = r_a - r_b;
            CMD_DIV: w_alu = w_drsp.quo;
            CMD_MOD: w_alu = w_drsp.rem;
            default: w_alu = w_prod;
        endcase
    end

    assign w_dreq.start = (r_state == S_EXE) && (r_cmd == CMD_DIV || r_cmd == CMD_MOD)
                          && (r_count >= CW'(2)) && (r_b != 32'd0);
    assign w_dreq.a     = r_a;
    assign w_dreq.b     = r_b;

    // Read address follows the sequencer step.
    always_comb begin
        case (r_state)
            S_IDLE:  w_raddr = PW'(r_count - CW'(1));
            S_RDB:   w_raddr = PW'(r_count - CW'(2));
            default: w_raddr = PW'(r_idx - CW'(1));
        endcase
    end

    assign w_oslot       = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_we     <= 1'b0;
            r_wait   <= 1'b0;
        end else begin
            r_we <= 1'b0;
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_cmd   <= s_axis_tuser;
                        r_opnd  <= s_axis_tdata;
                        r_state <= S_RDB;
                    end
                end
                S_RDB: begin
                    // The top entry lands first.
                    r_b     <= r_rdata;
                    r_state <= S_RDA;
                end
                S_RDA: begin
                    r_a     <= r_rdata;
                    r_state <= S_EXE;
                end
                S_EXE: begin
                    r_res_status <= ST_OK;
                    r_res_has    <= 1'b0;
                    r_res_val    <= '0;
                    r_res_char   <= 1'b0;
                    r_state      <= S_OUT;
                    case (r_cmd) inside
                        CMD_PUSH: begin
                            if (r_count == CW'(STACK_DEPTH)) begin
                                r_res_status <= ST_FULL;
                            end else begin
                                r_we    <= 1'b1;
                                r_waddr <= PW'(r_count);
                                r_wdata <= r_opnd;
                                r_count <= r_count + CW'(1);
                            end
                        end
                        CMD_POP: begin
                            if (r_count == '0) r_res_status <= ST_SHORT;
                            else r_count <= r_count - CW'(1);
                        end
                        CMD_SWAP, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
                            if (r_count < CW'(2)) begin
                                r_res_status <= ST_SHORT;
                            end else if ((r_cmd == CMD_DIV || r_cmd == CMD_MOD)
                                         && r_b == 32'd0) begin
                                r_res_status <= ST_DIVZERO;
                            end else if (r_cmd == CMD_DIV || r_cmd == CMD_MOD) begin
                                r_state <= S_DIV;
                            end else begin
                                r_state <= S_WR2;
                            end
                        end
                        CMD_PINT, CMD_PCHAR: begin
                            if (r_count == '0) begin
                                r_res_status <= ST_SHORT;
                            end else if (r_cmd == CMD_PCHAR && r_b > CHAR_MAX) begin
                                r_res_status <= ST_RANGE;
                            end else begin
                                r_res_has  <= 1'b1;
                                r_res_val  <= r_b;
                                r_res_char <= (r_cmd == CMD_PCHAR);
                            end
                        end
                        CMD_PALL: begin
                            if (r_count != '0) begin
                                r_idx   <= r_count;
                                r_wait  <= 1'b1;
                                r_state <= S_PALL;
                            end
                        end
                        CMD_NOP: begin
                        end
                        default: r_res_status <= ST_UNKNOWN;
                    endcase
                end
                S_DIV: begin
                    if (w_drsp.done) begin
                        r_we    <= 1'b1;
                        r_waddr <= PW'(r_count - CW'(2));
                        r_wdata <= w_alu;
                        r_count <= r_count - CW'(1);
                        r_state <= S_OUT;
                    end
                end
                S_WR2: begin
                    // Swap writes two entries; arithmetic writes one.
                    r_we <= 1'b1;
                    if (r_cmd == CMD_SWAP) begin
                        if (!r_wait) begin
                            r_waddr <= PW'(r_count - CW'(1));
                            r_wdata <= r_a;
                            r_wait  <= 1'b1;
                        end else begin
                            r_waddr <= PW'(r_count - CW'(2));
                            r_wdata <= r_b;
                            r_wait  <= 1'b0;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_waddr <= PW'(r_count - CW'(2));
                        r_wdata <= w_alu;
                        r_count <= r_count - CW'(1);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // The result moves to the output register once it is free.
                    if (w_oslot) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_res_status;
                        r_ohas    <= r_res_has;
                        r_oval    <= r_res_val;
                        r_ochar   <= r_res_char;
                        r_olast   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_PALL: begin
                    // Read is issued for r_idx - 1; r_wait covers the registered read until the data lands.
                    if (r_wait) begin
                        r_wait <= 1'b0;
                    end else if (w_oslot) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= ST_OK;
                        r_ohas    <= 1'b1;
                        r_oval    <= r_rdata;
                        r_ochar   <= 1'b0;
                        r_olast   <= (r_idx == CW'(1));
                        r_idx     <= r_idx - CW'(1);
                        r_wait    <= (r_idx != CW'(1));
                        if (r_idx == CW'(1)) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_oval, r_ostatus};
    assign m_axis_tuser  = {r_ochar, r_ohas};
    assign m_axis_tlast  = r_olast;

    `SME_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(STACK_DEPTH))
    `SME_ASSERT_NXT(a_hold, i_clk, i_rst_n, r_ovalid && !m_axis_tready, r_ovalid)
    `SME_ASSERT_IMP(a_err_clean, i_clk, i_rst_n, r_ovalid && r_ostatus != ST_OK,
                    !r_ohas && r_olast)
    `SME_ASSERT_IMP(a_busy, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready)
endmodule
